// ===== src/box_table_overlap_query_top_macros.svh =====
// Assertion macros for the box table overlap query block
`ifndef BOX_TABLE_OVERLAP_QUERY_TOP_MACROS_SVH
`define BOX_TABLE_OVERLAP_QUERY_TOP_MACROS_SVH
// implication checked on every clock edge outside reset
`define BTOQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define BTOQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== src/btoq_pkg.sv =====
// Package for the box table overlap query block: widths, op codes, entry type
package btoq_pkg;
  localparam int MaxBoxes = 64;
  localparam int CoordW = 24;
  localparam int OpW = 4;
  localparam int IdxW = 6;
  localparam int CountW = 7;

  typedef enum logic [OpW-1:0] {
    OP_LOAD = 4'd0, OP_OVERLAP = 4'd1, OP_HBLOCK = 4'd2, OP_VBLOCK = 4'd3,
    OP_HTOUCH = 4'd4, OP_VTOUCH = 4'd5, OP_TL = 4'd6, OP_TR = 4'd7,
    OP_TT = 4'd8, OP_TB = 4'd9, OP_TANY = 4'd10, OP_ML = 4'd11,
    OP_MR = 4'd12, OP_MT = 4'd13, OP_MB = 4'd14, OP_NONE = 4'd15
  } op_t;

  typedef struct packed {
    logic signed [CoordW-1:0] min_x;
    logic signed [CoordW-1:0] min_z;
    logic signed [CoordW-1:0] max_x;
    logic signed [CoordW-1:0] max_z;
    logic                     portal;
  } box_t;

  localparam int BoxW = 4 * CoordW + 1;
endpackage

// ===== src/box_table_overlap_query_top.sv =====
// Top level of the box table overlap query block
// Op 0 loads one box entry; op 15 answers without a scan. Every other op scans
// entries 0..min(box_count,MAX_BOXES)-1 one per cycle through the single table
// RAM read port and answers once. A query first reads its subject entry (states
// S_SUBJ and S_SUBJW). It then scans, with a registered read ahead of each check,
// and stops at the first deciding entry. "Touch any" runs four side scans. The
// input is stalled from accept until the answer moves into the output register,
// and is ready again once it is there. A result waiting in the output register
// does not block the next beat. Only a second finished answer waits for the
// receiver.
module box_table_overlap_query_top #(
  parameter int MAX_BOXES = btoq_pkg::MaxBoxes
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [btoq_pkg::OpW-1:0]           in_op,
  input  logic [btoq_pkg::IdxW-1:0]          in_index,
  input  logic signed [btoq_pkg::CoordW-1:0] in_x_lo,
  input  logic signed [btoq_pkg::CoordW-1:0] in_z_lo,
  input  logic signed [btoq_pkg::CoordW-1:0] in_x_hi,
  input  logic signed [btoq_pkg::CoordW-1:0] in_z_hi,
  input  logic signed [btoq_pkg::CoordW-1:0] in_line_pos,
  input  logic                               in_skip_portal,
  input  logic                               in_is_portal,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_result_flag,
  output logic                               out_block_found,
  output logic [btoq_pkg::IdxW-1:0]          out_block_index,
  input  logic                               cfg_we,
  input  logic [btoq_pkg::CountW-1:0]        cfg_data
);
  localparam int AW = $clog2(MAX_BOXES);
  localparam int NW = $clog2(MAX_BOXES + 1);
  localparam int CW = btoq_pkg::CoordW;

  typedef enum logic [2:0] {S_IDLE, S_SUBJ, S_SUBJW, S_SCAN, S_DONE} state_t;

  state_t state_r;
  logic [btoq_pkg::CountW-1:0] count_r;
  btoq_pkg::op_t op_r;
  logic [btoq_pkg::IdxW-1:0] idx_r;
  logic signed [CW-1:0] xl_r, zl_r, xh_r, zh_r, lp_r;
  logic corr_r, portal_r;
  btoq_pkg::box_t subj_r;
  logic [1:0] side_r;
  logic [NW-1:0] rd_n_r;      // next entry address to read
  logic [NW-1:0] ck_n_r;      // entry whose data is on the read port
  logic ck_v_r;
  logic flag_r, found_r;
  logic [btoq_pkg::IdxW-1:0] bidx_r;
  logic out_valid_r, out_flag_r, out_found_r;
  logic [btoq_pkg::IdxW-1:0] out_bidx_r;

  logic ram_we;
  logic [AW-1:0] ram_raddr;
  logic [btoq_pkg::BoxW-1:0] ram_wdata, ram_rdata;
  btoq_pkg::box_t e;
  logic [NW-1:0] cnt;
  logic idx_ok;
  logic scan_end;
  logic out_load;

  assign e = btoq_pkg::box_t'(ram_rdata);
  assign ram_wdata = {xl_r, zl_r, xh_r, zh_r, portal_r};
  assign ram_we = (state_r == S_SUBJ) && (op_r == btoq_pkg::OP_LOAD) && idx_ok;
  assign idx_ok = ({{(32-btoq_pkg::IdxW){1'b0}}, idx_r} < MAX_BOXES);
  assign cnt = (count_r > btoq_pkg::CountW'(MAX_BOXES)) ? NW'(MAX_BOXES) :
               NW'(count_r);
  assign ram_raddr = (state_r == S_SUBJ) ? idx_r[AW-1:0] : rd_n_r[AW-1:0];
  // all entries checked: nothing on the read port and no address left
  assign scan_end = !ck_v_r && (rd_n_r >= cnt);
  // finished answer moves out when the output register is free or being taken
  assign out_load = (state_r == S_DONE) && (!out_valid_r || !out_stall);

  btoq_ram #(.Width(btoq_pkg::BoxW), .Depth(MAX_BOXES)) u_ram (
    .clk(clk), .we(ram_we), .waddr(idx_r[AW-1:0]), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata)
  );

  // per-entry evaluation: hit decides the scan early
  logic hit, is_map, skip;
  logic signed [CW-1:0] a, b, lo, hi, elo, ehi;
  always_comb begin
    logic horz, sp, ov;
    hit = 1'b0;
    horz = (op_r == btoq_pkg::OP_HBLOCK) || (op_r == btoq_pkg::OP_HTOUCH);
    a = horz ? zl_r : xl_r;
    b = horz ? zh_r : xh_r;
    elo = horz ? e.min_x : e.min_z;
    ehi = horz ? e.max_x : e.max_z;
    lo = horz ? e.min_z : e.min_x;
    hi = horz ? e.max_z : e.max_x;
    is_map = (op_r >= btoq_pkg::OP_ML) && (op_r <= btoq_pkg::OP_MB);
    skip = (32'(idx_r) == 32'(ck_n_r));
    sp = 1'b0;
    ov = 1'b0;
    unique case (op_r)
      btoq_pkg::OP_OVERLAP:
        hit = !(corr_r && e.portal) && !(zh_r <= e.min_z || xh_r <= e.min_x) &&
              !(xl_r >= e.max_x || zl_r >= e.max_z);
      btoq_pkg::OP_HBLOCK, btoq_pkg::OP_VBLOCK,
      btoq_pkg::OP_HTOUCH, btoq_pkg::OP_VTOUCH: begin
        sp = (a >= lo && a < hi) || (b > lo && b <= hi);
        if (op_r == btoq_pkg::OP_HTOUCH || op_r == btoq_pkg::OP_VTOUCH)
          sp = sp || (lo >= a && lo <= b) || (hi >= a && hi <= b);
        hit = (elo == lp_r || ehi == lp_r) && sp;
      end
      btoq_pkg::OP_TL, btoq_pkg::OP_TR, btoq_pkg::OP_TT, btoq_pkg::OP_TB,
      btoq_pkg::OP_TANY: begin
        if (!side_r[1])
          ov = (e.min_z >= subj_r.min_z && e.min_z < subj_r.max_z) ||
               (e.max_z > subj_r.min_z && e.max_z <= subj_r.max_z);
        else
          ov = (e.min_x >= subj_r.min_x && e.min_x < subj_r.max_x) ||
               (e.max_x > subj_r.min_x && e.max_x <= subj_r.max_x);
        unique case (side_r)
          2'd0: hit = subj_r.min_x == e.max_x;
          2'd1: hit = subj_r.max_x == e.min_x;
          2'd2: hit = subj_r.min_z == e.max_z;
          default: hit = subj_r.max_z == e.min_z;
        endcase
        hit = hit && ov && e.portal;
      end
      btoq_pkg::OP_ML, btoq_pkg::OP_MR, btoq_pkg::OP_MT, btoq_pkg::OP_MB: begin
        if (!side_r[1])
          ov = (subj_r.min_z >= e.min_z && subj_r.min_z < e.max_z) ||
               (subj_r.max_z > e.min_z && subj_r.max_z <= e.max_z);
        else
          ov = (subj_r.min_x >= e.min_x && subj_r.min_x < e.max_x) ||
               (subj_r.max_x > e.min_x && subj_r.max_x <= e.max_x);
        unique case (side_r)
          2'd0: hit = e.max_x < subj_r.min_x;
          2'd1: hit = e.min_x > subj_r.max_x;
          2'd2: hit = e.max_z < subj_r.min_z;
          default: hit = e.min_z > subj_r.max_z;
        endcase
        hit = hit && ov;
      end
      default: hit = 1'b0;
    endcase
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_result_flag = out_flag_r;
  assign out_block_found = out_found_r;
  assign out_block_index = out_bidx_r;

  // sequencer and registered results
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) count_r <= cfg_data;

      // output register: load a finished answer or release a taken beat
      if (out_load) begin
        out_valid_r <= 1'b1;
        out_flag_r <= flag_r;
        out_found_r <= found_r;
        out_bidx_r <= bidx_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: if (in_valid) begin
          op_r <= btoq_pkg::op_t'(in_op);
          idx_r <= in_index;
          xl_r <= in_x_lo; zl_r <= in_z_lo; xh_r <= in_x_hi; zh_r <= in_z_hi;
          lp_r <= in_line_pos;
          corr_r <= in_skip_portal;
          portal_r <= in_is_portal;
          flag_r <= 1'b0; found_r <= 1'b0; bidx_r <= '0;
          state_r <= S_SUBJ;
        end
        S_SUBJ: begin
          if (op_r == btoq_pkg::OP_LOAD || op_r == btoq_pkg::OP_NONE)
            state_r <= S_DONE;
          else if (op_r >= btoq_pkg::OP_TL && !idx_ok)
            state_r <= S_DONE;
          else begin
            state_r <= S_SUBJW;
            side_r <= (op_r >= btoq_pkg::OP_ML) ? 2'(op_r - btoq_pkg::OP_ML) :
                      (op_r == btoq_pkg::OP_TANY) ? 2'd0 : 2'(op_r - btoq_pkg::OP_TL);
          end
        end
        S_SUBJW: begin
          subj_r <= e;
          rd_n_r <= '0;
          ck_v_r <= 1'b0;
          flag_r <= is_map;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          ck_n_r <= rd_n_r;
          if (ck_v_r && !skip && hit) begin
            flag_r <= !is_map;
            if (op_r == btoq_pkg::OP_HBLOCK || op_r == btoq_pkg::OP_VBLOCK) begin
              found_r <= 1'b1;
              bidx_r <= btoq_pkg::IdxW'(ck_n_r);
            end
            state_r <= S_DONE;
          end else if (scan_end) begin
            if (op_r == btoq_pkg::OP_TANY && side_r != 2'd3) begin
              side_r <= side_r + 2'd1;
              rd_n_r <= '0;
              ck_v_r <= 1'b0;
            end else state_r <= S_DONE;
          end else begin
            ck_v_r <= (rd_n_r < cnt);
            if (rd_n_r < cnt) rd_n_r <= rd_n_r + 1'b1;
          end
        end
        S_DONE: if (out_load) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== src/btoq_ram.sv =====
// Generic single-port-write, registered-read RAM
module btoq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== src/btoq_checker.sv =====
// Port-level checker for the box table overlap query block, with bind
`include "box_table_overlap_query_top_macros.svh"
module btoq_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic out_result_flag,
  input logic out_block_found,
  input logic [btoq_pkg::IdxW-1:0] out_block_index
);
  `BTOQ_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_result_flag), "stalled result changed")
  `BTOQ_ASSERT_IMP(a_found_flag, out_valid && out_block_found, out_result_flag, "found without flag")
  `BTOQ_ASSERT_IMP(a_idx_zero, out_valid && !out_block_found, out_block_index == '0, "index without found")
  `BTOQ_ASSERT_NXT(a_accept_busy, in_valid && !in_stall, in_stall, "not busy after accept")
endmodule

bind box_table_overlap_query_top btoq_checker u_btoq_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_result_flag(out_result_flag),
  .out_block_found(out_block_found), .out_block_index(out_block_index)
);

// ===== sim/tb_top.sv =====
// Testbench for the box table overlap query block: scoreboard, stimulus and checks
module tb_top;
  import btoq_pkg::*;

  typedef logic signed [CoordW-1:0] coord_t;

  typedef struct {
    op_t             op;
    logic [IdxW-1:0] index;
    coord_t          x_lo, z_lo, x_hi, z_hi, line_pos;
    logic            skip_portal, is_portal;
  } query_t;

  typedef struct {
    logic            flag;
    logic            found;
    logic [IdxW-1:0] bidx;
  } answer_t;

  // Shadow box table plus queue of answers still owed by the block
  class box_scoreboard;
    coord_t  min_x[MaxBoxes], min_z[MaxBoxes], max_x[MaxBoxes], max_z[MaxBoxes];
    logic    portal[MaxBoxes];
    int      box_count;
    answer_t owed[$];
    int      errors;

    function int scan_len();
      return (box_count > MaxBoxes) ? MaxBoxes : box_count;
    endfunction

    // a in [lo,hi) or b in (lo,hi]
    function bit span(coord_t a, coord_t b, coord_t lo, coord_t hi);
      return (a >= lo && a < hi) || (b > lo && b <= hi);
    endfunction

    function bit touches(int s, int side);
      bit ov;
      for (int n = 0; n < scan_len(); n++) begin
        if (n == s || !portal[n]) continue;
        ov = (side < 2) ? span(min_z[n], max_z[n], min_z[s], max_z[s])
                        : span(min_x[n], max_x[n], min_x[s], max_x[s]);
        if (!ov) continue;
        if (side == 0 && min_x[s] == max_x[n]) return 1;
        if (side == 1 && max_x[s] == min_x[n]) return 1;
        if (side == 2 && min_z[s] == max_z[n]) return 1;
        if (side == 3 && max_z[s] == min_z[n]) return 1;
      end
      return 0;
    endfunction

    function bit on_edge(int s, int side);
      bit ov;
      for (int n = 0; n < scan_len(); n++) begin
        if (n == s) continue;
        ov = (side < 2) ? span(min_z[s], max_z[s], min_z[n], max_z[n])
                        : span(min_x[s], max_x[s], min_x[n], max_x[n]);
        if (!ov) continue;
        if (side == 0 && max_x[n] < min_x[s]) return 0;
        if (side == 1 && min_x[n] > max_x[s]) return 0;
        if (side == 2 && max_z[n] < min_z[s]) return 0;
        if (side == 3 && min_z[n] > max_z[s]) return 0;
      end
      return 1;
    endfunction

    // Accepted input beat: update the table and queue the answer
    function void note_input(query_t q);
      answer_t a;
      bit      horz;
      coord_t  lo, hi, elo, ehi, qa, qb;
      int      s;
      a = '{0, 0, 0};
      s = q.index;
      case (q.op)
        OP_LOAD: begin
          min_x[s] = q.x_lo; min_z[s] = q.z_lo;
          max_x[s] = q.x_hi; max_z[s] = q.z_hi;
          portal[s] = q.is_portal;
        end
        OP_OVERLAP:
          for (int n = 0; n < scan_len() && !a.flag; n++) begin
            if (n == s || (q.skip_portal && portal[n])) continue;
            if (q.z_hi <= min_z[n] || q.x_hi <= min_x[n]) continue;
            if (q.x_lo >= max_x[n] || q.z_lo >= max_z[n]) continue;
            a.flag = 1;
          end
        OP_HBLOCK, OP_VBLOCK, OP_HTOUCH, OP_VTOUCH: begin
          horz = (q.op == OP_HBLOCK || q.op == OP_HTOUCH);
          qa = horz ? q.z_lo : q.x_lo;
          qb = horz ? q.z_hi : q.x_hi;
          for (int n = 0; n < scan_len() && !a.flag; n++) begin
            if (n == s) continue;
            elo = horz ? min_x[n] : min_z[n];
            ehi = horz ? max_x[n] : max_z[n];
            lo  = horz ? min_z[n] : min_x[n];
            hi  = horz ? max_z[n] : max_x[n];
            if (elo != q.line_pos && ehi != q.line_pos) continue;
            if (span(qa, qb, lo, hi)) a.flag = 1;
            else if ((q.op == OP_HTOUCH || q.op == OP_VTOUCH) &&
                     ((lo >= qa && lo <= qb) || (hi >= qa && hi <= qb))) a.flag = 1;
            if (a.flag && (q.op == OP_HBLOCK || q.op == OP_VBLOCK)) begin
              a.found = 1;
              a.bidx = IdxW'(n);
            end
          end
        end
        OP_TL, OP_TR, OP_TT, OP_TB: a.flag = touches(s, q.op - OP_TL);
        OP_TANY: a.flag = touches(s, 0) || touches(s, 1) || touches(s, 2) || touches(s, 3);
        OP_ML, OP_MR, OP_MT, OP_MB: a.flag = on_edge(s, q.op - OP_ML);
        default: ;
      endcase
      owed.push_back(a);
    endfunction

    // Accepted result beat: compare with the oldest owed answer
    function void check_result(logic flag, logic found, logic [IdxW-1:0] bidx);
      answer_t e;
      if (owed.size() == 0) begin
        $display("%0t: unexpected result flag=%0b found=%0b index=%0d",
                 $time, flag, found, bidx);
        errors++;
        return;
      end
      e = owed.pop_front();
      if (flag !== e.flag) begin
        $display("%0t: result_flag expected %0b actual %0b", $time, e.flag, flag);
        errors++;
      end
      if (found !== e.found) begin
        $display("%0t: block_found expected %0b actual %0b", $time, e.found, found);
        errors++;
      end
      if (bidx !== e.bidx) begin
        $display("%0t: block_index expected %0d actual %0d", $time, e.bidx, bidx);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, in_stall;
  op_t  in_op = OP_NONE;
  logic [IdxW-1:0] in_index = '0;
  coord_t in_x_lo = '0, in_z_lo = '0, in_x_hi = '0, in_z_hi = '0, in_line_pos = '0;
  logic in_skip_portal = 0, in_is_portal = 0;
  logic out_valid, out_stall = 0;
  logic out_result_flag, out_block_found;
  logic [IdxW-1:0] out_block_index;
  logic cfg_we = 0;
  logic [CountW-1:0] cfg_data = '0;

  box_scoreboard sb = new();
  int idle_pct = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  always #6 clk = ~clk;

  box_table_overlap_query_top dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_op, .in_index, .in_x_lo, .in_z_lo,
    .in_x_hi, .in_z_hi, .in_line_pos, .in_skip_portal, .in_is_portal,
    .out_valid, .out_stall, .out_result_flag, .out_block_found, .out_block_index,
    .cfg_we, .cfg_data
  );

  // receiver back-pressure
  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // monitors and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        sb.note_input('{in_op, in_index, in_x_lo, in_z_lo, in_x_hi, in_z_hi,
                        in_line_pos, in_skip_portal, in_is_portal});
      end
      if (out_valid && !out_stall)
        sb.check_result(out_result_flag, out_block_found, out_block_index);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= 20000) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // mostly small coordinates so boxes meet; sometimes anything
  function coord_t rand_coord();
    if ($urandom_range(9) == 0) return coord_t'($urandom);
    return coord_t'($urandom_range(16)) - 8;
  endfunction

  // present one beat and hold it until taken, then maybe go idle
  task send(query_t q);
    in_valid <= 1;
    in_op <= q.op; in_index <= q.index;
    in_x_lo <= q.x_lo; in_z_lo <= q.z_lo; in_x_hi <= q.x_hi; in_z_hi <= q.z_hi;
    in_line_pos <= q.line_pos;
    in_skip_portal <= q.skip_portal; in_is_portal <= q.is_portal;
    do @(posedge clk); while (!(in_valid && !in_stall));
    if ($urandom_range(99) < idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
  endtask

  task drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task set_count(int v);
    drain();
    cfg_we <= 1;
    cfg_data <= v[CountW-1:0];
    sb.box_count = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  function query_t random_load(int idx);
    query_t q;
    q.op = OP_LOAD;
    q.index = idx;
    q.x_lo = rand_coord();
    q.z_lo = rand_coord();
    q.x_hi = ($urandom_range(7) == 0) ? rand_coord() : q.x_lo + $urandom_range(6);
    q.z_hi = ($urandom_range(7) == 0) ? rand_coord() : q.z_lo + $urandom_range(6);
    q.line_pos = rand_coord();
    q.skip_portal = $urandom_range(1);
    q.is_portal = $urandom_range(1);
    return q;
  endfunction

  function query_t random_query();
    query_t q;
    q = random_load($urandom_range(MaxBoxes - 1));
    if ($urandom_range(4) != 0) begin
      q.op = op_t'($urandom_range(1, 14));
      q.line_pos = ($urandom_range(3) == 0) ? rand_coord() : coord_t'($urandom_range(16)) - 8;
    end else if ($urandom_range(19) == 0) begin
      q.op = OP_NONE;
    end
    return q;
  endfunction

  initial begin
    query_t q;
    int counts[8] = '{64, 5, 127, 1, 40, 0, 64, 2};
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // fill every entry so no scan reads an unwritten box
    for (int i = 0; i < MaxBoxes; i++) send(random_load(i));

    // directed: ops 1 to 7 on an empty scan, every op on an oversized count and a full table
    foreach (counts[c]) begin
      if (c > 2) break;
      set_count(c == 0 ? 0 : (c == 1 ? 127 : 64));
      for (int o = 1; o <= 15; o++) begin
        q = random_load(o == 15 ? 63 : 0);
        q.op = op_t'(o);
        q.skip_portal = o[0];
        if (c == 2) begin
          q.x_lo = coord_t'(24'h800000); q.z_lo = coord_t'(24'h800000);
          q.x_hi = coord_t'(24'h7fffff); q.z_hi = coord_t'(24'h7fffff);
          q.line_pos = (o[0]) ? coord_t'(24'h7fffff) : coord_t'(24'h800000);
        end
        if (c != 0 || o < 8) send(q);
      end
    end
    // extreme load values on the last entry
    q = random_load(63);
    q.x_lo = coord_t'(24'h800000); q.z_lo = coord_t'(24'h7fffff);
    q.x_hi = coord_t'(24'h7fffff); q.z_hi = coord_t'(24'h800000);
    q.is_portal = 1;
    send(q);

    // random phases over idle/stall mixes and counts
    for (int p = 0; p < 8; p++) begin
      set_count(counts[p]);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 86; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 86; end
        default: begin idle_pct = 24; stall_pct = 24; end
      endcase
      for (int i = 0; i < 250; i++) begin
        if (i == 125 && p == 3) drain();
        send(random_query());
      end
    end

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.owed.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
